// File: hdl/iaa_pkg.sv
// Shared types, constants and helpers of the interval arithmetic unit.
package iaa_pkg;

  localparam int FIELD_W = 32;
  localparam int EXT_W   = 64;

  typedef enum logic [3:0] {
    CMD_ADD        = 4'd0,
    CMD_SUB        = 4'd1,
    CMD_MUL        = 4'd2,
    CMD_DIV        = 4'd3,
    CMD_HULL       = 4'd4,
    CMD_WIDEN      = 4'd5,
    CMD_INC        = 4'd6,
    CMD_DEC        = 4'd7,
    CMD_SCALE_UP   = 4'd8,
    CMD_SCALE_DOWN = 4'd9
  } cmd_t;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [EXT_W-1:0]   ext_t;

  // Stage one: raw corner products, plain bounds and division control.
  typedef struct packed {
    logic   v;
    cmd_t   cmd;
    field_t al;
    field_t ah;
    ext_t   p0;
    ext_t   p1;
    ext_t   p2;
    ext_t   p3;
    ext_t   plain_lo;
    ext_t   plain_hi;
    logic   wide;
    logic   neg_lo;
    logic   neg_hi;
  } front_t;

  // Everything but the quotients, waiting for the divider.
  typedef struct packed {
    logic   v;
    cmd_t   cmd;
    field_t al;
    field_t ah;
    ext_t   lo;
    ext_t   hi;
    logic   wide;
    logic   neg_lo;
    logic   neg_hi;
  } early_t;

  function automatic ext_t min2(ext_t x, ext_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic ext_t max2(ext_t x, ext_t y);
    return (x > y) ? x : y;
  endfunction

endpackage

// File: hdl/iaa_front.sv
// Input register and first stage: corner products, plain bounds, division set-up.
module iaa_front
  import iaa_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int NW        = FIELD_W + FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [3:0]          cmd,
  input  logic signed [31:0]  a_low,
  input  logic signed [31:0]  a_high,
  input  logic signed [31:0]  b_low,
  input  logic signed [31:0]  b_high,
  output front_t              s1,
  output logic [NW-1:0]       num_lo,
  output logic [NW-1:0]       num_hi,
  output logic [FIELD_W-1:0]  den_lo,
  output logic [FIELD_W-1:0]  den_hi
);

  logic   v0;
  cmd_t   cmd0;
  field_t al0, ah0, bl0, bh0;

  ext_t   eal, eah, ebl, ebh;
  ext_t   plain_lo, plain_hi;
  field_t x_lo, y_lo, x_hi, y_hi;
  logic   wide;

  function automatic logic [FIELD_W-1:0] mag(field_t x);
    logic [FIELD_W-1:0] u;
    u = x;
    return x[FIELD_W-1] ? (~u + 1'b1) : u;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= start;
    end
    cmd0 <= cmd_t'(cmd);
    al0  <= a_low;
    ah0  <= a_high;
    bl0  <= b_low;
    bh0  <= b_high;
  end

  always_comb begin
    eal = EXT_W'(al0);
    eah = EXT_W'(ah0);
    ebl = EXT_W'(bl0);
    ebh = EXT_W'(bh0);
    unique case (cmd0)
      CMD_ADD: begin
        plain_lo = eal + ebl;
        plain_hi = eah + ebh;
      end
      CMD_SUB: begin
        plain_lo = min2(eal - ebl, eal - ebh);
        plain_hi = max2(eah - ebl, eah - ebh);
      end
      CMD_HULL, CMD_WIDEN: begin
        plain_lo = min2(eal, ebl);
        plain_hi = max2(eah, ebh);
      end
      CMD_INC: begin
        plain_lo = min2(eal, eal + ebl);
        plain_hi = max2(eah, eah + ebh);
      end
      CMD_DEC: begin
        plain_lo = min2(eal, eal - ebh);
        plain_hi = max2(eah, eah - ebl);
      end
      default: begin
        plain_lo = eal;
        plain_hi = eah;
      end
    endcase
  end

  // Pick dividend and divisor for each bound by the signs of A and B.
  always_comb begin
    x_lo = '0;
    y_lo = '0;
    x_hi = '0;
    y_hi = '0;
    wide = 1'b0;
    priority if (al0 >= 0) begin
      priority if (bl0 > 0) begin
        x_lo = al0; y_lo = bh0; x_hi = ah0; y_hi = bl0;
      end else if (bh0 < 0) begin
        x_lo = ah0; y_lo = bh0; x_hi = al0; y_hi = bl0;
      end else begin
        wide = 1'b1;
      end
    end else if (ah0 <= 0) begin
      priority if (bl0 > 0) begin
        x_lo = al0; y_lo = bl0; x_hi = ah0; y_hi = bh0;
      end else if (bh0 < 0) begin
        x_lo = ah0; y_lo = bl0; x_hi = al0; y_hi = bh0;
      end else begin
        wide = 1'b1;
      end
    end else begin
      wide = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.v <= 1'b0;
    end else begin
      s1.v <= v0;
    end
    s1.cmd      <= cmd0;
    s1.al       <= al0;
    s1.ah       <= ah0;
    s1.p0       <= al0 * bl0;
    s1.p1       <= al0 * bh0;
    s1.p2       <= ah0 * bl0;
    s1.p3       <= ah0 * bh0;
    s1.plain_lo <= plain_lo;
    s1.plain_hi <= plain_hi;
    s1.wide     <= wide || (y_lo == 0) || (y_hi == 0);
    s1.neg_lo   <= x_lo[FIELD_W-1] ^ y_lo[FIELD_W-1];
    s1.neg_hi   <= x_hi[FIELD_W-1] ^ y_hi[FIELD_W-1];
    num_lo      <= NW'(mag(x_lo)) << FRAC_BITS;
    num_hi      <= NW'(mag(x_hi)) << FRAC_BITS;
    den_lo      <= mag(y_lo);
    den_hi      <= mag(y_hi);
  end

endmodule

// File: hdl/iaa_divider.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module iaa_divider #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [NW-1:0] nq_r  [1:NW];
  logic [DW-1:0] rem_r [1:NW];
  logic [DW-1:0] dv_r  [1:NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] dv_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_first
      assign nq_in  = num;
      assign rem_in = '0;
      assign dv_in  = den;
    end else begin : g_next
      assign nq_in  = nq_r[i];
      assign rem_in = rem_r[i];
      assign dv_in  = dv_r[i];
    end

    assign trial = {rem_in, nq_in[NW-1]};
    assign diff  = trial - {1'b0, dv_in};
    assign take  = trial >= {1'b0, dv_in};

    // Shift the dividend out and the quotient in through one register.
    always_ff @(posedge clk) begin
      nq_r[i+1]  <= {nq_in[NW-2:0], take};
      rem_r[i+1] <= take ? diff[DW-1:0] : trial[DW-1:0];
      dv_r[i+1]  <= dv_in;
    end
  end

  assign quo = nq_r[NW];

endmodule

// File: hdl/iaa_select.sv
// Product scaling, corner min/max and per-command bounds ahead of the divider.
module iaa_select
  import iaa_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  front_t s1,
  output early_t s3
);

  typedef struct packed {
    logic   v;
    cmd_t   cmd;
    field_t al;
    field_t ah;
    ext_t   plain_lo;
    ext_t   plain_hi;
    ext_t   mul_lo;
    ext_t   mul_hi;
    logic   wide;
    logic   neg_lo;
    logic   neg_hi;
  } mid_t;

  mid_t s2;
  ext_t q0, q1, q2, q3;
  ext_t lo, hi;
  ext_t eal, eah;

  // Arithmetic shift floors toward minus infinity.
  assign q0 = s1.p0 >>> FRAC_BITS;
  assign q1 = s1.p1 >>> FRAC_BITS;
  assign q2 = s1.p2 >>> FRAC_BITS;
  assign q3 = s1.p3 >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.v <= 1'b0;
    end else begin
      s2.v <= s1.v;
    end
    s2.cmd      <= s1.cmd;
    s2.al       <= s1.al;
    s2.ah       <= s1.ah;
    s2.plain_lo <= s1.plain_lo;
    s2.plain_hi <= s1.plain_hi;
    s2.mul_lo   <= min2(min2(q0, q1), min2(q2, q3));
    s2.mul_hi   <= max2(max2(q0, q1), max2(q2, q3));
    s2.wide     <= s1.wide;
    s2.neg_lo   <= s1.neg_lo;
    s2.neg_hi   <= s1.neg_hi;
  end

  always_comb begin
    eal = EXT_W'(s2.al);
    eah = EXT_W'(s2.ah);
    unique case (s2.cmd)
      CMD_MUL: begin
        lo = s2.mul_lo;
        hi = s2.mul_hi;
      end
      CMD_SCALE_UP: begin
        lo = min2(eal, s2.mul_lo);
        hi = max2(eah, s2.mul_hi);
      end
      default: begin
        lo = s2.plain_lo;
        hi = s2.plain_hi;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.v <= 1'b0;
    end else begin
      s3.v <= s2.v;
    end
    s3.cmd    <= s2.cmd;
    s3.al     <= s2.al;
    s3.ah     <= s2.ah;
    s3.lo     <= lo;
    s3.hi     <= hi;
    s3.wide   <= s2.wide;
    s3.neg_lo <= s2.neg_lo;
    s3.neg_hi <= s2.neg_hi;
  end

endmodule

// File: hdl/iaa_finish.sv
// Quotient sign fix, division merge, clamp to word limits and result register.
module iaa_finish
  import iaa_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int NW        = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  early_t              e,
  input  logic [NW-1:0]       qmag_lo,
  input  logic [NW-1:0]       qmag_hi,
  output logic                done,
  output logic signed [31:0]  r_low,
  output logic signed [31:0]  r_high,
  output logic                unbounded,
  output logic                saturated
);

  localparam int   BB   = (WORD_BITS > FIELD_W) ? FIELD_W : WORD_BITS;
  localparam ext_t WMAX = (EXT_W'(1) << (BB - 1)) - EXT_W'(1);
  localparam ext_t WMIN = ~WMAX;

  typedef struct packed {
    early_t e;
    ext_t   q_lo;
    ext_t   q_hi;
  } fix_t;

  typedef struct packed {
    logic v;
    ext_t lo;
    ext_t hi;
    logic unb;
  } comb_t;

  fix_t  f1;
  comb_t f2;
  ext_t  qe_lo, qe_hi, tl, th;
  comb_t f2_next;

  assign qe_lo = EXT_W'(qmag_lo);
  assign qe_hi = EXT_W'(qmag_hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      f1.e.v <= 1'b0;
    end else begin
      f1.e.v <= e.v;
    end
    f1.e.cmd    <= e.cmd;
    f1.e.al     <= e.al;
    f1.e.ah     <= e.ah;
    f1.e.lo     <= e.lo;
    f1.e.hi     <= e.hi;
    f1.e.wide   <= e.wide;
    f1.e.neg_lo <= e.neg_lo;
    f1.e.neg_hi <= e.neg_hi;
    f1.q_lo     <= e.neg_lo ? -qe_lo : qe_lo;
    f1.q_hi     <= e.neg_hi ? -qe_hi : qe_hi;
  end

  always_comb begin
    tl = f1.e.wide ? WMIN : f1.q_lo;
    th = f1.e.wide ? WMAX : f1.q_hi;
    f2_next.v = f1.e.v;
    unique case (f1.e.cmd)
      CMD_DIV: begin
        f2_next.lo  = tl;
        f2_next.hi  = th;
        f2_next.unb = f1.e.wide;
      end
      CMD_SCALE_DOWN: begin
        f2_next.lo  = min2(EXT_W'(f1.e.al), tl);
        f2_next.hi  = max2(EXT_W'(f1.e.ah), th);
        f2_next.unb = f1.e.wide;
      end
      default: begin
        f2_next.lo  = f1.e.lo;
        f2_next.hi  = f1.e.hi;
        f2_next.unb = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f2.v <= 1'b0;
    end else begin
      f2.v <= f2_next.v;
    end
    f2.lo  <= f2_next.lo;
    f2.hi  <= f2_next.hi;
    f2.unb <= f2_next.unb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f2.v;
    end
    r_low     <= (f2.lo > WMAX) ? WMAX[31:0] : (f2.lo < WMIN) ? WMIN[31:0] : f2.lo[31:0];
    r_high    <= (f2.hi > WMAX) ? WMAX[31:0] : (f2.hi < WMIN) ? WMIN[31:0] : f2.hi[31:0];
    unbounded <= f2.unb;
    saturated <= (f2.lo > WMAX) || (f2.lo < WMIN) || (f2.hi > WMAX) || (f2.hi < WMIN);
  end

endmodule

// File: hdl/interval_arithmetic_alu.sv
// Top level of the pipelined interval arithmetic unit.
//
//  channel   ports                                   beat taken when
//  -------   -------------------------------------   ---------------------
//  command   start, busy, cmd, a_low..b_high         start high, busy low
//  result    done, r_low, r_high, unbounded,         done high (one cycle)
//            saturated
//
// One command beat a cycle; busy is held low, the pipeline never stalls.
// A result leaves through the input register, the set-up stage and the divider,
// with one stage per bit of the 32 + FRAC_BITS bit quotient, then through the
// sign-fix, merge and clamp stages.
// Reset clears only the valid bits; the receiver cannot stall, so done is a
// one-cycle strobe and results leave in command order.
module interval_arithmetic_alu
  import iaa_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [3:0]          cmd,
  input  logic signed [31:0]  a_low,
  input  logic signed [31:0]  a_high,
  input  logic signed [31:0]  b_low,
  input  logic signed [31:0]  b_high,
  output logic                done,
  output logic signed [31:0]  r_low,
  output logic signed [31:0]  r_high,
  output logic                unbounded,
  output logic                saturated
);

  // Quotient width: magnitude of a 32-bit dividend scaled up by FRAC_BITS.
  localparam int NW  = FIELD_W + FRAC_BITS;
  // Hold the non-division bundle until the quotients come out.
  localparam int DLY = NW - 2;

  front_t             s1;
  early_t             s3;
  early_t             dly [0:DLY-1];
  logic [NW-1:0]      num_lo, num_hi, qmag_lo, qmag_hi;
  logic [FIELD_W-1:0] den_lo, den_hi;

  // Every cycle takes a new beat.
  assign busy = 1'b0;

  iaa_front #(
    .FRAC_BITS (FRAC_BITS),
    .NW        (NW)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .a_low  (a_low),
    .a_high (a_high),
    .b_low  (b_low),
    .b_high (b_high),
    .s1     (s1),
    .num_lo (num_lo),
    .num_hi (num_hi),
    .den_lo (den_lo),
    .den_hi (den_hi)
  );

  // Two dividers side by side: one for each bound.
  iaa_divider #(
    .NW (NW),
    .DW (FIELD_W)
  ) u_div_lo (
    .clk (clk),
    .num (num_lo),
    .den (den_lo),
    .quo (qmag_lo)
  );

  iaa_divider #(
    .NW (NW),
    .DW (FIELD_W)
  ) u_div_hi (
    .clk (clk),
    .num (num_hi),
    .den (den_hi),
    .quo (qmag_hi)
  );

  iaa_select #(
    .FRAC_BITS (FRAC_BITS)
  ) u_select (
    .clk (clk),
    .rst (rst),
    .s1  (s1),
    .s3  (s3)
  );

  // Delay line: advance the bundle one place a cycle, valid bit with it.
  for (genvar k = 0; k < DLY; k++) begin : g_dly
    early_t src;
    if (k == 0) begin : g_head
      assign src = s3;
    end else begin : g_tail
      assign src = dly[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dly[k].v <= 1'b0;
      end else begin
        dly[k].v <= src.v;
      end
      dly[k].cmd    <= src.cmd;
      dly[k].al     <= src.al;
      dly[k].ah     <= src.ah;
      dly[k].lo     <= src.lo;
      dly[k].hi     <= src.hi;
      dly[k].wide   <= src.wide;
      dly[k].neg_lo <= src.neg_lo;
      dly[k].neg_hi <= src.neg_hi;
    end
  end

  iaa_finish #(
    .WORD_BITS (WORD_BITS),
    .NW        (NW)
  ) u_finish (
    .clk       (clk),
    .rst       (rst),
    .e         (dly[DLY-1]),
    .qmag_lo   (qmag_lo),
    .qmag_hi   (qmag_hi),
    .done      (done),
    .r_low     (r_low),
    .r_high    (r_high),
    .unbounded (unbounded),
    .saturated (saturated)
  );

endmodule

// File: tb/interval_arithmetic_alu_checker.sv
// Result predictor and scoreboard for the interval arithmetic unit.
`timescale 1ns / 100ps
module interval_arithmetic_alu_checker
  import iaa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [3:0]         cmd,
  input  logic signed [31:0] a_low,
  input  logic signed [31:0] a_high,
  input  logic signed [31:0] b_low,
  input  logic signed [31:0] b_high,
  input  logic               done,
  input  logic signed [31:0] r_low,
  input  logic signed [31:0] r_high,
  input  logic               unbounded,
  input  logic               saturated,
  output int                 fail_count,
  output int                 pending
);

  localparam int FRAC = 16;
  localparam longint BOUND_MAX = 64'sd2147483647;
  localparam longint BOUND_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               unb;
    logic               sat;
  } bounds_t;

  bounds_t intervals_due[$];

  function automatic longint lesser(longint x, longint y);
    return x < y ? x : y;
  endfunction

  function automatic longint greater(longint x, longint y);
    return x > y ? x : y;
  endfunction

  // Product shifted down, rounded toward minus infinity.
  function automatic longint fixed_product(longint x, longint y);
    return (x * y) >>> FRAC;
  endfunction

  function automatic void corner_span(longint al, longint ah, longint bl, longint bh,
                                      output longint lo, output longint hi);
    longint p0, p1, p2, p3;
    p0 = fixed_product(al, bl);
    p1 = fixed_product(al, bh);
    p2 = fixed_product(ah, bl);
    p3 = fixed_product(ah, bh);
    lo = lesser(lesser(p0, p1), lesser(p2, p3));
    hi = greater(greater(p0, p1), greater(p2, p3));
  endfunction

  // Quotient truncated toward zero; a zero divisor gives the widest interval.
  function automatic bit fixed_quotient(longint x, longint y, output longint q);
    q = 0;
    if (y == 0) return 1'b1;
    q = (x * (64'sd1 <<< FRAC)) / y;
    return 1'b0;
  endfunction

  function automatic bit quotient_span(longint al, longint ah, longint bl, longint bh,
                                       output longint lo, output longint hi);
    bit wide;
    lo = 0;
    hi = 0;
    wide = 1'b1;
    if (al >= 0) begin
      if (bl > 0) wide = fixed_quotient(al, bh, lo) || fixed_quotient(ah, bl, hi);
      else if (bh < 0) wide = fixed_quotient(ah, bh, lo) || fixed_quotient(al, bl, hi);
    end else if (ah <= 0) begin
      if (bl > 0) wide = fixed_quotient(al, bl, lo) || fixed_quotient(ah, bh, hi);
      else if (bh < 0) wide = fixed_quotient(ah, bl, lo) || fixed_quotient(al, bh, hi);
    end
    if (wide) begin
      lo = BOUND_MIN;
      hi = BOUND_MAX;
    end
    return wide;
  endfunction

  function automatic longint clip(longint v, ref bit sat);
    if (v > BOUND_MAX) begin
      sat = 1'b1;
      return BOUND_MAX;
    end
    if (v < BOUND_MIN) begin
      sat = 1'b1;
      return BOUND_MIN;
    end
    return v;
  endfunction

  function automatic bounds_t interval_result(logic [3:0] op, longint al, longint ah,
                                              longint bl, longint bh);
    longint lo, hi, tl, th;
    bit unb, sat;
    bounds_t r;
    lo = al;
    hi = ah;
    unb = 1'b0;
    sat = 1'b0;
    case (op)
      CMD_ADD: begin
        lo = al + bl;
        hi = ah + bh;
      end
      CMD_SUB: begin
        lo = lesser(al - bl, al - bh);
        hi = greater(ah - bl, ah - bh);
      end
      CMD_MUL: corner_span(al, ah, bl, bh, lo, hi);
      CMD_DIV: unb = quotient_span(al, ah, bl, bh, lo, hi);
      CMD_HULL, CMD_WIDEN: begin
        lo = lesser(al, bl);
        hi = greater(ah, bh);
      end
      CMD_INC: begin
        lo = lesser(al, al + bl);
        hi = greater(ah, ah + bh);
      end
      CMD_DEC: begin
        lo = lesser(al, al - bh);
        hi = greater(ah, ah - bl);
      end
      CMD_SCALE_UP: begin
        corner_span(al, ah, bl, bh, tl, th);
        lo = lesser(al, tl);
        hi = greater(ah, th);
      end
      CMD_SCALE_DOWN: begin
        unb = quotient_span(al, ah, bl, bh, tl, th);
        lo = lesser(al, tl);
        hi = greater(ah, th);
      end
      default: ;
    endcase
    r.lo = 32'(clip(lo, sat));
    r.hi = 32'(clip(hi, sat));
    r.unb = unb;
    r.sat = sat;
    return r;
  endfunction

  assign pending = intervals_due.size();

  always @(posedge clk) begin
    bounds_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      // Predict every accepted command beat.
      if (start && !busy)
        intervals_due.push_back(interval_result(cmd, a_low, a_high, b_low, b_high));
      // Compare each result beat against the oldest prediction.
      if (done) begin
        if (intervals_due.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat at %0t", $time);
          fail_count <= fail_count + 1;
        end else begin
          want = intervals_due.pop_front();
          if (want.lo !== r_low || want.hi !== r_high ||
              want.unb !== unbounded || want.sat !== saturated) begin
            if (fail_count < 10)
              $display("mismatch at %0t: want [%0d,%0d] u%0b s%0b got [%0d,%0d] u%0b s%0b",
                       $time, want.lo, want.hi, want.unb, want.sat,
                       r_low, r_high, unbounded, saturated);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/interval_arithmetic_alu_test.sv
// Stimulus and verdict for the interval arithmetic unit.
`timescale 1ns / 100ps
module interval_arithmetic_alu_test;
  import iaa_pkg::*;

  localparam int LATENCY = 52;
  localparam int RANDOM_BEATS = 1500;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [3:0]         cmd = '0;
  logic signed [31:0] a_low = '0, a_high = '0, b_low = '0, b_high = '0;
  logic               done;
  logic signed [31:0] r_low, r_high;
  logic               unbounded, saturated;
  int                 fail_count, pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  interval_arithmetic_alu dut (.*);
  interval_arithmetic_alu_checker scoreboard (.*);

  // Pick a bound: modest values half the time, else extremes, zero or full-range noise.
  function automatic logic signed [31:0] pick_bound();
    case ($urandom_range(9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3, 4: return $urandom();
      5: return $signed($urandom_range(32'h7_FFFF)) - 32'sh4_0000;
      default: return $signed($urandom_range(32'h3FF_FFFF)) - 32'sh200_0000;
    endcase
  endfunction

  // Drive one command beat and hold it until it is taken.
  task automatic send_beat(logic [3:0] op, logic signed [31:0] al, logic signed [31:0] ah,
                           logic signed [31:0] bl, logic signed [31:0] bh);
    start  <= 1'b1;
    cmd    <= op;
    a_low  <= al;
    a_high <= ah;
    b_low  <= bl;
    b_high <= bh;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a burst of idle cycles.
  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 15)) @(posedge clk);
  endtask

  initial begin
    logic signed [31:0] al, ah, bl, bh;
    logic [3:0] op;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every command on ordinary intervals, including unused codes.
    for (int c = 0; c < 16; c++)
      send_beat(4'(c), -32'sh3_0000, 32'sh5_8000, 32'sh2_0000, 32'sh4_0000);
    // Extremes: add overflow, saturating products, divisor and dividend straddling zero,
    // a malformed divisor with a zero bound, saturating quotients, malformed sub and dec.
    send_beat(CMD_ADD, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_beat(CMD_MUL, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_beat(CMD_DIV, 32'sh1_0000, 32'sh2_0000, -32'sh1_0000, 32'sh1_0000);
    send_beat(CMD_DIV, -32'sh1_0000, 32'sh2_0000, 32'sh1_0000, 32'sh2_0000);
    send_beat(CMD_DIV, 32'sh1_0000, 32'sh2_0000, 32'sh1_0000, 32'sh0);
    send_beat(CMD_DIV, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh1, 32'sh1);
    send_beat(CMD_SCALE_DOWN, 32'sh8000_0000, -32'sh1, -32'sh1, -32'sh1);
    send_beat(CMD_SUB, 32'sh5_0000, -32'sh5_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_beat(CMD_DEC, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);

    // Hold off until the pipeline has drained once.
    start <= 1'b0;
    while (pending != 0) @(posedge clk);

    // Random: mostly well-formed intervals, a share malformed.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      op = ($urandom_range(19) == 0) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(9));
      al = pick_bound();
      ah = pick_bound();
      bl = pick_bound();
      bh = pick_bound();
      if ($urandom_range(4) != 0) begin
        if (al > ah) {al, ah} = {ah, al};
        if (bl > bh) {bl, bh} = {bh, bl};
      end
      // Idle in bursts, none in the last stretch of the run.
      if (n < RANDOM_BEATS - 200 && $urandom_range(5) == 0) idle_burst();
      send_beat(op, al, ah, bl, bh);
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
hdl/iaa_pkg.sv
hdl/iaa_front.sv
hdl/iaa_divider.sv
hdl/iaa_select.sv
hdl/iaa_finish.sv
hdl/interval_arithmetic_alu.sv
tb/interval_arithmetic_alu_checker.sv
tb/interval_arithmetic_alu_test.sv
